>>> rtl/pal_pkg.sv
package pal_pkg;

   // Operation codes carried in the request beat.
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_INSERT = 2'd2;
   localparam logic [1:0] OP_DELETE = 2'd3;

   // Number of cells folded into one registered partial read result.
   localparam int GROUP_SIZE = 8;

   typedef struct packed {
      logic [1:0]  operation;
      logic [6:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        status;
      logic [6:0]  list_length;
      logic        list_empty;
      logic        past_end;
   } rsp_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      logic       go;
      logic [1:0] op;
   } cell_cmd_type;

endpackage

>>> rtl/pal_cell.sv
module pal_cell #(
   parameter int DATA_WIDTH = 32,
   parameter int SLOT_WIDTH = 8,
   parameter int INDEX      = 0
) (
   input  logic                      clock,
   input  pal_pkg::cell_cmd_type     cmd,
   input  logic [SLOT_WIDTH-1:0]     slot,
   input  logic [DATA_WIDTH-1:0]     wval,
   input  logic [DATA_WIDTH-1:0]     left,
   input  logic [DATA_WIDTH-1:0]     right,
   output logic [DATA_WIDTH-1:0]     data,
   output logic [DATA_WIDTH-1:0]     rd
);
   import pal_pkg::*;

   localparam logic [SLOT_WIDTH-1:0] MY_INDEX = SLOT_WIDTH'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff;
   logic [DATA_WIDTH-1:0] entry_in;
   logic                  hit;
   logic                  above;

   assign hit   = (slot == MY_INDEX);
   assign above = (slot < MY_INDEX);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.go) begin
         case (cmd.op)
            OP_WRITE: begin
               if (hit) entry_in = wval;
            end
            OP_INSERT: begin
               // Entries behind the slot move one place towards the tail.
               if (hit) entry_in = wval;
               else if (above) entry_in = left;
            end
            OP_DELETE: begin
               if (hit || above) entry_in = right;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign data = entry_ff;
   assign rd   = (cmd.go && cmd.op == OP_READ && hit) ? entry_ff : '0;

endmodule

>>> rtl/pal_read_tree.sv
module pal_read_tree #(
   parameter int DATA_WIDTH = 32,
   parameter int DEPTH      = 64
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [DATA_WIDTH-1:0] cell_rd [DEPTH],
   output logic [DATA_WIDTH-1:0] rd_out
);
   import pal_pkg::*;

   localparam int NUM_GROUPS = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   logic [DATA_WIDTH-1:0] group_in [NUM_GROUPS];
   logic [DATA_WIDTH-1:0] group_ff [NUM_GROUPS];

   // At most one cell drives a non-zero value, so an OR selects it.
   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         group_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < DEPTH) begin
               group_in[g] = group_in[g] | cell_rd[g * GROUP_SIZE + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         group_ff <= group_in;
      end
   end

   always_comb begin
      rd_out = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         rd_out = rd_out | group_ff[g];
      end
   end

endmodule

>>> rtl/positional_array_list_top.sv
// Positional array list: up to DEPTH entries kept packed at positions 1 to length.
// Request beats (req_valid, req_stall, req_data) carry an operation, a 1-based
// position and a value; each request yields exactly one response beat on
// rsp_valid, rsp_stall, rsp_data with the read data, the ignore flag, the
// length after the operation, an empty flag and a past-end flag.
// The entries live in a chain of cells, one entry per cell. A write, insert or
// delete is broadcast to every cell at the accepting edge, and each cell loads
// its own value, the new value or a neighbour's value, so a new request can be
// taken in every cycle while req_stall is low, whatever its operation.
// Read data is folded from the cells through a registered OR tree, so a
// response passes through the registered group results and then the output
// register, and throughput is one beat per cycle while the receiver does not stall.
// When the receiver stalls, the pipeline holds and req_stall rises as soon as
// both internal stages are occupied; no beat is lost or repeated.
// Reset clears the length and both valid flags. Cell contents are not reset:
// an entry is only ever read once it has been written.
module positional_array_list_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pal_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pal_pkg::rsp_type rsp_data
);
   import pal_pkg::*;

   localparam int LEN_WIDTH  = $clog2(DEPTH + 1);
   // Wide enough for the position, the length and length plus one.
   localparam int CMP_WIDTH  = ((LEN_WIDTH > 7) ? LEN_WIDTH : 7) + 1;

   localparam logic [LEN_WIDTH-1:0] FULL_LEN = LEN_WIDTH'(DEPTH);

   // Length of the list, cleared by reset.
   logic [LEN_WIDTH-1:0]  length_ff;
   logic [LEN_WIDTH-1:0]  length_in;

   // Pipeline control.
   logic                  a_valid_ff;
   logic                  rsp_valid_ff;
   logic                  adv_b;
   logic                  adv_a;
   logic                  accept;

   // Status fields travelling beside the read tree.
   rsp_type               a_meta_ff;
   rsp_type               a_meta_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   // Decoded request.
   logic [CMP_WIDTH-1:0]  pos_c;
   logic [CMP_WIDTH-1:0]  len_c;
   logic [CMP_WIDTH-1:0]  new_len_c;
   logic [CMP_WIDTH-1:0]  slot;
   logic                  in_range;
   logic                  ins_ok;
   logic                  done;
   logic [DATA_WIDTH-1:0] wval;
   cell_cmd_type          cmd;

   // Chain wiring.
   logic [DATA_WIDTH-1:0] cell_data [DEPTH];
   logic [DATA_WIDTH-1:0] cell_rd   [DEPTH];
   logic [DATA_WIDTH-1:0] tree_rd;

   // The output register advances when it is empty or its beat is taken;
   // the middle stage advances when it is empty or moves on.
   assign adv_b     = !rsp_valid_ff || !rsp_stall;
   assign adv_a     = !a_valid_ff || adv_b;
   assign req_stall = !adv_a;
   assign accept    = req_valid && adv_a;

   assign pos_c    = CMP_WIDTH'(req_data.position);
   assign len_c    = CMP_WIDTH'(length_ff);
   assign in_range = (pos_c != '0) && (pos_c <= len_c);
   assign ins_ok   = (length_ff != FULL_LEN) && (pos_c <= len_c + CMP_WIDTH'(1));
   // For an insert, position 0 also addresses the front of the list; other operations at position 0 are ignored.
   assign slot     = (pos_c == '0) ? '0 : pos_c - CMP_WIDTH'(1);
   assign wval     = DATA_WIDTH'(req_data.value);

   always_comb begin
      case (req_data.operation)
         OP_INSERT: done = ins_ok;
         default:   done = in_range;
      endcase
   end

   always_comb begin
      length_in = length_ff;
      if (accept && done) begin
         if (req_data.operation == OP_INSERT) begin
            length_in = length_ff + LEN_WIDTH'(1);
         end else if (req_data.operation == OP_DELETE) begin
            length_in = length_ff - LEN_WIDTH'(1);
         end
      end
   end

   assign new_len_c = CMP_WIDTH'(length_in);
   assign cmd.go    = accept && done;
   assign cmd.op    = req_data.operation;

   always_comb begin
      a_meta_in             = '0;
      a_meta_in.status      = !done;
      a_meta_in.list_length = 7'(length_in);
      a_meta_in.list_empty  = (length_in == '0);
      a_meta_in.past_end    = (pos_c > new_len_c);
   end

   // The cell chain: each cell sees the cell in front of it and the one behind.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_w;
      logic [DATA_WIDTH-1:0] right_w;

      if (i == 0) begin : g_head
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_w = cell_data[i];
      end else begin : g_mid_r
         assign right_w = cell_data[i+1];
      end

      pal_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .SLOT_WIDTH (CMP_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock (clock),
         .cmd   (cmd),
         .slot  (slot),
         .wval  (wval),
         .left  (left_w),
         .right (right_w),
         .data  (cell_data[i]),
         .rd    (cell_rd[i])
      );
   end

   pal_read_tree #(
      .DATA_WIDTH (DATA_WIDTH),
      .DEPTH      (DEPTH)
   ) u_read_tree (
      .clock   (clock),
      .en      (adv_a),
      .cell_rd (cell_rd),
      .rd_out  (tree_rd)
   );

   // The response beat takes its status fields from the middle stage and its
   // read data from the tree.
   always_comb begin
      rsp_in           = a_meta_ff;
      rsp_in.read_data = 32'(tree_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff <= length_in;
         if (adv_a) begin
            a_valid_ff <= accept;
         end
         if (adv_b) begin
            rsp_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         a_meta_ff <= a_meta_in;
      end
      if (adv_b) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
